FILE: src/sps_pkg.sv
// shared types and constants of the servo pluck sequencer
package sps_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PLUCK = 2'd1,
        OP_MUTE  = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] CFG_PLUCK_ANGLE  = 3'd0;
    localparam logic [2:0] CFG_OPEN_WAIT    = 3'd1;
    localparam logic [2:0] CFG_CLOSE_WAIT   = 3'd2;
    localparam logic [2:0] CFG_IDLE_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_PULSE_MIN    = 3'd4;
    localparam logic [2:0] CFG_PULSE_MAX    = 3'd5;
    localparam logic [2:0] CFG_PWM_FREQ     = 3'd6;

    // init sequence phases
    typedef enum logic [4:0] {
        PH_OPENING    = 5'b00001,
        PH_WAIT_OPEN  = 5'b00010,
        PH_CLOSING    = 5'b00100,
        PH_WAIT_CLOSE = 5'b01000,
        PH_COMPLETE   = 5'b10000
    } phase_t;

    // serial arithmetic sequencer states
    typedef enum logic [6:0] {
        SQ_IDLE  = 7'b0000001,
        SQ_MUL1  = 7'b0000010,
        SQ_DIV1  = 7'b0000100,
        SQ_PULSE = 7'b0001000,
        SQ_MUL2  = 7'b0010000,
        SQ_SCALE = 7'b0100000,
        SQ_DIV2  = 7'b1000000
    } seq_t;

    // field and register widths
    localparam int CFG_W   = 24;
    localparam int PLUCK_W = 7;
    localparam int WAIT_W  = 16;
    localparam int IDLE_W  = 24;
    localparam int PULSE_W = 15;
    localparam int FREQ_W  = 11;
    localparam int CNT_W   = 12;
    localparam int TGT_W   = 11;
    localparam int ACC_W   = 26;
    localparam int REM_W   = 14;
    localparam int QUO_W   = 15;
    localparam int STEP_W  = 5;

    // register reset values
    localparam logic [PLUCK_W-1:0] PLUCK_RESET   = 7'd20;
    localparam logic [WAIT_W-1:0]  OPEN_RESET    = 16'd300;
    localparam logic [WAIT_W-1:0]  CLOSE_RESET   = 16'd300;
    localparam logic [IDLE_W-1:0]  TIMEOUT_RESET = 24'd5000;
    localparam logic [PULSE_W-1:0] PMIN_RESET    = 15'd500;
    localparam logic [PULSE_W-1:0] PMAX_RESET    = 15'd2500;
    localparam logic [FREQ_W-1:0]  FREQ_RESET    = 11'd50;
    localparam logic [7:0]         REST_RESET    = 8'd90;

    // angle range floor
    localparam int ANGLE_MIN = 0;

    // serial step counts
    localparam int MUL_STEPS = 11;
    localparam int DIV_STEPS = 26;

    // count = pulse * freq * 4096 / 1e6 = (pulse * freq * 64) / 15625
    localparam logic [REM_W-1:0] PWM_DIVISOR = 14'd15625;
    localparam logic [ACC_W-1:0] PWM_SAT     = 26'd1000000;
    localparam int               PWM_SHIFT   = 6;
    localparam logic [CNT_W-1:0] CNT_MAX     = 12'd4095;

endpackage

FILE: src/servo_pluck_sequencer_core.sv
// servo pluck sequencer: init sequence, pluck/mute/load handling, serial pwm mapping
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  config   | cfg_we             | cfg_index, cfg_data
//  input    | in_valid/in_ready  | op, servo, angle
//  output   | out_valid/out_ready| write_valid, channel, pwm_count,
//           |                    | outputs_enabled, init_done, bad_index
//
// a word that issues no pwm write gives its result registered, in the cycle after acceptance
// a word that writes a channel runs the bit-serial unit: 11 multiply steps,
// 26 divide steps, a pulse step, 11 multiply steps, a scale step and 26 divide
// steps; when the count saturates at 4095 the run ends at the scale step
// reset acts only on control and config registers; rest angles come up at 90 degrees
// the output register holds a result while out_ready is low; a new word is
// taken once the serial unit is idle and the output register is free or draining
module servo_pluck_sequencer_core
    import sps_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int ANGLE_MAX    = 180
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [7:0]       servo,
    input  logic [7:0]       angle,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             write_valid,
    output logic [3:0]       channel,
    output logic [CNT_W-1:0] pwm_count,
    output logic             outputs_enabled,
    output logic             init_done,
    output logic             bad_index
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ANG_W = $clog2(ANGLE_MAX + 1);
    localparam logic [CH_W-1:0]         LAST_CH    = CH_W'(NUM_CHANNELS - 1);
    localparam logic [7:0]              NUM_CH_B   = 8'(NUM_CHANNELS);
    localparam logic [REM_W-1:0]        ANGLE_SPAN = REM_W'(ANGLE_MAX - ANGLE_MIN);
    localparam logic signed [TGT_W-1:0] TGT_MIN    = TGT_W'(ANGLE_MIN);
    localparam logic signed [TGT_W-1:0] TGT_MAX    = TGT_W'(ANGLE_MAX);
    localparam logic [8:0]              LOAD_MAX   = 9'(ANGLE_MAX);
    localparam logic [STEP_W-1:0]       MUL_LAST   = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0]       DIV_LAST   = STEP_W'(DIV_STEPS - 1);

    // configuration registers
    logic [PLUCK_W-1:0] pluck_angle_reg;
    logic [WAIT_W-1:0]  open_wait_reg;
    logic [WAIT_W-1:0]  close_wait_reg;
    logic [IDLE_W-1:0]  idle_timeout_reg;
    logic [PULSE_W-1:0] pulse_min_reg;
    logic [PULSE_W-1:0] pulse_max_reg;
    logic [FREQ_W-1:0]  pwm_freq_reg;

    // sequencer state
    phase_t                  phase_reg, phase_next;
    logic [CH_W-1:0]         init_ch_reg, init_ch_next;
    logic [WAIT_W-1:0]       wait_reg, wait_next;
    logic [IDLE_W-1:0]       idle_reg, idle_next;
    logic                    enabled_reg, enabled_next;
    logic [NUM_CHANNELS-1:0] toggle_reg, toggle_next;
    logic [7:0]              rest_reg [NUM_CHANNELS];

    // serial arithmetic unit
    seq_t               seq_reg, seq_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [ACC_W-1:0]   mcand_reg, mcand_next;
    logic [FREQ_W-1:0]  mplier_reg, mplier_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               span_neg_reg, span_neg_next;
    logic [3:0]         wr_ch_reg, wr_ch_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               write_valid_reg, write_valid_next;
    logic [3:0]         channel_reg, channel_next;
    logic [CNT_W-1:0]   pwm_count_reg, pwm_count_next;
    logic               en_out_reg, en_out_next;
    logic               done_out_reg, done_out_next;
    logic               bad_out_reg, bad_out_next;

    // decode and datapath helpers
    op_t                      op_c;
    logic                     accept;
    logic                     servo_bad;
    logic [CH_W-1:0]          idx;
    logic [CH_W-1:0]          sel_idx;
    logic [7:0]               rest_sel;
    logic                     use_offset;
    logic                     go_up;
    logic signed [TGT_W-1:0]  rest_ext;
    logic signed [TGT_W-1:0]  pluck_ext;
    logic signed [TGT_W-1:0]  tgt;
    logic [ANG_W-1:0]         tgt_clamped;
    logic                     span_neg;
    logic [PULSE_W-1:0]       span_mag;
    logic [PULSE_W-1:0]       pulse_val;
    logic [IDLE_W-1:0]        idle_inc;
    logic [WAIT_W-1:0]        wait_inc;
    logic [WAIT_W-1:0]        wait_limit;
    logic [7:0]               rest_wdata;
    logic                     rest_we;
    logic [REM_W-1:0]         divisor;
    logic [REM_W:0]           rem_shift;
    logic [REM_W:0]           rem_sub;
    logic                     div_ge;

    // handshake
    assign accept    = in_valid && in_ready;
    assign in_ready  = (seq_reg == SQ_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    assign write_valid     = write_valid_reg;
    assign channel         = channel_reg;
    assign pwm_count       = pwm_count_reg;
    assign outputs_enabled = en_out_reg;
    assign init_done       = done_out_reg;
    assign bad_index       = bad_out_reg;

    // item decode
    assign op_c      = op_t'(op);
    assign servo_bad = (servo >= NUM_CH_B);
    assign idx       = servo[CH_W-1:0];
    assign sel_idx   = (op_c == OP_TICK) ? init_ch_reg : idx;
    assign rest_sel  = rest_reg[sel_idx];

    // target angle: rest, or rest offset up or down by the pluck angle
    assign use_offset = ((op_c == OP_TICK) && (phase_reg == PH_OPENING)) ||
                        (op_c == OP_PLUCK);
    assign go_up      = (op_c == OP_TICK) ? !init_ch_reg[0] : (toggle_reg[idx] ^ idx[0]);
    assign rest_ext   = $signed({3'b000, rest_sel});
    assign pluck_ext  = $signed({4'b0000, pluck_angle_reg});
    assign tgt        = !use_offset ? rest_ext :
                        go_up ? (rest_ext + pluck_ext) : (rest_ext - pluck_ext);
    assign tgt_clamped = (tgt < TGT_MIN) ? ANG_W'(ANGLE_MIN) :
                         (tgt > TGT_MAX) ? ANG_W'(ANGLE_MAX) : ANG_W'(tgt);

    // pulse span magnitude and sign
    assign span_neg = (pulse_max_reg < pulse_min_reg);
    assign span_mag = span_neg ? (pulse_min_reg - pulse_max_reg)
                               : (pulse_max_reg - pulse_min_reg);
    assign pulse_val = span_neg_reg ? (pulse_min_reg - quo_reg) : (pulse_min_reg + quo_reg);

    // saturating counters
    assign idle_inc   = (idle_reg != '1) ? (idle_reg + 1'b1) : idle_reg;
    assign wait_inc   = (wait_reg != '1) ? (wait_reg + 1'b1) : wait_reg;
    assign wait_limit = (phase_reg == PH_WAIT_OPEN) ? open_wait_reg : close_wait_reg;

    // rest angle load saturates at the angle ceiling
    assign rest_wdata = ({1'b0, angle} > LOAD_MAX) ? 8'(ANGLE_MAX) : angle;

    // restoring divide step, one quotient bit per cycle
    assign divisor   = (seq_reg == SQ_DIV1) ? ANGLE_SPAN : PWM_DIVISOR;
    assign rem_shift = {rem_reg, acc_reg[ACC_W-1]};
    assign rem_sub   = rem_shift - {1'b0, divisor};
    assign div_ge    = (rem_shift >= {1'b0, divisor});

    // next-state logic
    always_comb
    begin
        phase_next       = phase_reg;
        init_ch_next     = init_ch_reg;
        wait_next        = wait_reg;
        idle_next        = idle_reg;
        enabled_next     = enabled_reg;
        toggle_next      = toggle_reg;
        rest_we          = 1'b0;
        seq_next         = seq_reg;
        step_next        = step_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        span_neg_next    = span_neg_reg;
        wr_ch_next       = wr_ch_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        write_valid_next = write_valid_reg;
        channel_next     = channel_reg;
        pwm_count_next   = pwm_count_reg;
        en_out_next      = en_out_reg;
        done_out_next    = done_out_reg;
        bad_out_next     = bad_out_reg;

        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    // item handling
                    if (op_c == OP_TICK)
                    begin
                        idle_next = idle_inc;
                        unique case (phase_reg)
                            PH_OPENING:
                            begin
                                wait_next  = '0;
                                phase_next = PH_WAIT_OPEN;
                            end
                            PH_CLOSING:
                            begin
                                wait_next  = '0;
                                phase_next = PH_WAIT_CLOSE;
                            end
                            PH_WAIT_OPEN, PH_WAIT_CLOSE:
                            begin
                                wait_next = wait_inc;
                                if (wait_inc >= wait_limit)
                                begin
                                    if (init_ch_reg == LAST_CH)
                                    begin
                                        init_ch_next = '0;
                                        if (phase_reg == PH_WAIT_OPEN)
                                        begin
                                            phase_next = PH_CLOSING;
                                        end
                                        else
                                        begin
                                            enabled_next = 1'b0;
                                            phase_next   = PH_COMPLETE;
                                        end
                                    end
                                    else
                                    begin
                                        init_ch_next = init_ch_reg + 1'b1;
                                        phase_next   = (phase_reg == PH_WAIT_OPEN) ?
                                                       PH_OPENING : PH_CLOSING;
                                    end
                                end
                            end
                            default:
                            begin
                                if (enabled_reg && (idle_inc >= idle_timeout_reg))
                                begin
                                    enabled_next = 1'b0;
                                end
                            end
                        endcase
                    end
                    else if (!servo_bad)
                    begin
                        if (op_c == OP_LOAD)
                        begin
                            rest_we = 1'b1;
                        end
                        else
                        begin
                            enabled_next = 1'b1;
                            idle_next    = '0;
                            if (op_c == OP_PLUCK)
                            begin
                                toggle_next[idx] = ~toggle_reg[idx];
                            end
                        end
                    end

                    // start the serial mapping or give the result at once
                    if (((op_c == OP_TICK) &&
                         ((phase_reg == PH_OPENING) || (phase_reg == PH_CLOSING))) ||
                        (((op_c == OP_PLUCK) || (op_c == OP_MUTE)) && !servo_bad))
                    begin
                        seq_next      = SQ_MUL1;
                        step_next     = '0;
                        mcand_next    = ACC_W'(span_mag);
                        mplier_next   = FREQ_W'(tgt_clamped);
                        acc_next      = '0;
                        span_neg_next = span_neg;
                        wr_ch_next    = 4'(sel_idx);
                    end
                    else
                    begin
                        out_valid_next   = 1'b1;
                        write_valid_next = 1'b0;
                        channel_next     = '0;
                        pwm_count_next   = '0;
                        en_out_next      = enabled_next;
                        done_out_next    = (phase_next == PH_COMPLETE);
                        bad_out_next     = (op_c != OP_TICK) && servo_bad;
                    end
                end
            end

            // shift-add multiply, one multiplier bit per cycle
            SQ_MUL1, SQ_MUL2:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg + 1'b1;
                if (step_reg == MUL_LAST)
                begin
                    step_next = '0;
                    rem_next  = '0;
                    quo_next  = '0;
                    seq_next  = (seq_reg == SQ_MUL1) ? SQ_DIV1 : SQ_SCALE;
                end
            end

            // restoring divide over the accumulator bits
            SQ_DIV1, SQ_DIV2:
            begin
                rem_next  = div_ge ? REM_W'(rem_sub) : REM_W'(rem_shift);
                acc_next  = acc_reg << 1;
                quo_next  = {quo_reg[QUO_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    step_next = '0;
                    if (seq_reg == SQ_DIV1)
                    begin
                        seq_next = SQ_PULSE;
                    end
                    else
                    begin
                        seq_next         = SQ_IDLE;
                        out_valid_next   = 1'b1;
                        write_valid_next = 1'b1;
                        channel_next     = wr_ch_reg;
                        pwm_count_next   = {quo_reg[CNT_W-2:0], div_ge};
                        en_out_next      = enabled_reg;
                        done_out_next    = (phase_reg == PH_COMPLETE);
                        bad_out_next     = 1'b0;
                    end
                end
            end

            // pulse width ready, set up pulse times frequency
            SQ_PULSE:
            begin
                mcand_next  = ACC_W'(pulse_val);
                mplier_next = pwm_freq_reg;
                acc_next    = '0;
                step_next   = '0;
                seq_next    = SQ_MUL2;
            end

            // saturate, or pre-scale by 64 for the final divide
            SQ_SCALE:
            begin
                if (acc_reg >= PWM_SAT)
                begin
                    seq_next         = SQ_IDLE;
                    out_valid_next   = 1'b1;
                    write_valid_next = 1'b1;
                    channel_next     = wr_ch_reg;
                    pwm_count_next   = CNT_MAX;
                    en_out_next      = enabled_reg;
                    done_out_next    = (phase_reg == PH_COMPLETE);
                    bad_out_next     = 1'b0;
                end
                else
                begin
                    acc_next  = acc_reg << PWM_SHIFT;
                    rem_next  = '0;
                    quo_next  = '0;
                    step_next = '0;
                    seq_next  = SQ_DIV2;
                end
            end

            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pluck_angle_reg  <= PLUCK_RESET;
            open_wait_reg    <= OPEN_RESET;
            close_wait_reg   <= CLOSE_RESET;
            idle_timeout_reg <= TIMEOUT_RESET;
            pulse_min_reg    <= PMIN_RESET;
            pulse_max_reg    <= PMAX_RESET;
            pwm_freq_reg     <= FREQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PLUCK_ANGLE:  pluck_angle_reg  <= cfg_data[PLUCK_W-1:0];
                CFG_OPEN_WAIT:    open_wait_reg    <= cfg_data[WAIT_W-1:0];
                CFG_CLOSE_WAIT:   close_wait_reg   <= cfg_data[WAIT_W-1:0];
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data[IDLE_W-1:0];
                CFG_PULSE_MIN:    pulse_min_reg    <= cfg_data[PULSE_W-1:0];
                CFG_PULSE_MAX:    pulse_max_reg    <= cfg_data[PULSE_W-1:0];
                CFG_PWM_FREQ:     pwm_freq_reg     <= cfg_data[FREQ_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OPENING;
            init_ch_reg   <= '0;
            wait_reg      <= '0;
            idle_reg      <= '0;
            enabled_reg   <= 1'b1;
            toggle_reg    <= '0;
            seq_reg       <= SQ_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                rest_reg[i] <= REST_RESET;
            end
        end
        else
        begin
            phase_reg     <= phase_next;
            init_ch_reg   <= init_ch_next;
            wait_reg      <= wait_next;
            idle_reg      <= idle_next;
            enabled_reg   <= enabled_next;
            toggle_reg    <= toggle_next;
            seq_reg       <= seq_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (rest_we)
            begin
                rest_reg[idx] <= rest_wdata;
            end
        end
    end

    // serial datapath and output word
    always_ff @(posedge clk)
    begin
        mcand_reg       <= mcand_next;
        mplier_reg      <= mplier_next;
        acc_reg         <= acc_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        span_neg_reg    <= span_neg_next;
        wr_ch_reg       <= wr_ch_next;
        write_valid_reg <= write_valid_next;
        channel_reg     <= channel_next;
        pwm_count_reg   <= pwm_count_next;
        en_out_reg      <= en_out_next;
        done_out_reg    <= done_out_next;
        bad_out_reg     <= bad_out_next;
    end

endmodule
